@@ hdl/mas_pkg.sv @@
package mas_pkg;

    localparam int unsigned ADDR_W    = 32;
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned NUM_TABLE = 8;
    localparam int unsigned REGION_W  = 3;
    localparam int unsigned OFFSET_W  = 17;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_RESP  = 2'd2;

    localparam logic KIND_ACCESS = 1'b0;
    localparam logic KIND_DONE   = 1'b1;

    localparam logic [OFFSET_W-1:0] REGION_SIZE [NUM_TABLE] = '{
        17'd118476, 17'h04000, 17'h00170, 17'h00FFF,
        17'h00FFF,  17'h00FFF, 17'h00080, 17'h10000
    };

    localparam logic [ADDR_W-1:0] BASE_RESET [NUM_TABLE] = '{
        32'h2040_0000, 32'h8000_0000, 32'h1000_0000, 32'h1000_8000,
        32'h1001_2000, 32'h1001_3000, 32'h1001_4000, 32'h0200_0000
    };

    typedef struct packed {
        logic                kind;
        logic [REGION_W-1:0] region;
        logic [OFFSET_W-1:0] offset;
        logic                is_write;
        logic [3:0]          byte_mask;
        logic [DATA_W-1:0]   data;
        logic                ok;
    } t_result;

    typedef struct packed {
        logic                hit;
        logic [REGION_W-1:0] region;
        logic [OFFSET_W-1:0] offset;
    } t_lookup;

    function automatic logic [3:0] lane_bits(input logic [2:0] width);
        logic [3:0] bits;
        unique case (width)
            3'd1:    bits = 4'h1;
            3'd2:    bits = 4'h3;
            default: bits = 4'hF;
        endcase
        return bits;
    endfunction

    function automatic logic [DATA_W-1:0] value_mask(input logic [2:0] width);
        logic [DATA_W-1:0] mask;
        unique case (width)
            3'd1:    mask = 32'h0000_00FF;
            3'd2:    mask = 32'h0000_FFFF;
            default: mask = 32'hFFFF_FFFF;
        endcase
        return mask;
    endfunction

endpackage

@@ hdl/mas_decode.sv @@
module mas_decode
    import mas_pkg::*;
#(
    parameter int unsigned NUM_LIVE = 8
) (
    input  logic [NUM_LIVE-1:0][ADDR_W-1:0] i_bases,
    input  logic [ADDR_W-1:0]               i_word,
    output t_lookup                         o_lookup
);

    // Scanning from the last region down lets the first region in table order win.
    always_comb begin
        logic [ADDR_W:0] lo;
        logic [ADDR_W:0] hi;
        logic [ADDR_W:0] word_x;
        o_lookup = '0;
        word_x   = {1'b0, i_word};
        for (int i = NUM_LIVE - 1; i >= 0; i--) begin
            lo = {1'b0, i_bases[i]};
            hi = lo + (ADDR_W + 1)'(REGION_SIZE[i]);
            if (word_x >= lo && word_x < hi) begin
                o_lookup.hit    = (word_x + (ADDR_W + 1)'(4)) <= hi;
                o_lookup.region = REGION_W'(i);
                o_lookup.offset = i_word[OFFSET_W-1:0] - i_bases[i][OFFSET_W-1:0];
            end
        end
    end

endmodule

@@ hdl/mas_lanes.sv @@
module mas_lanes
    import mas_pkg::*;
(
    input  logic [1:0]        i_lane,
    input  logic [2:0]        i_width,
    input  logic              i_part,
    input  logic              i_second,
    input  logic [DATA_W-1:0] i_write_data,
    input  logic [DATA_W-1:0] i_first_word,
    input  logic [DATA_W-1:0] i_resp_data,
    output logic              o_spill,
    output logic [3:0]        o_byte_mask,
    output logic [DATA_W-1:0] o_wr_word,
    output logic [DATA_W-1:0] o_rd_value
);

    logic [6:0]          spread;
    logic [2*DATA_W-1:0] wide;
    logic [2*DATA_W-1:0] merged;

    assign spread = 7'(lane_bits(i_width)) << i_lane;
    assign wide   = (2*DATA_W)'(i_write_data) << {i_lane, 3'b000};
    assign merged = {i_resp_data, i_first_word} >> {i_lane, 3'b000};

    assign o_spill     = spread[6:4] != 3'b000;
    assign o_byte_mask = i_part ? {1'b0, spread[6:4]} : spread[3:0];
    assign o_wr_word   = i_part ? wide[2*DATA_W-1:DATA_W] : wide[DATA_W-1:0];
    assign o_rd_value  = (i_second ? merged[DATA_W-1:0] : i_resp_data) & value_mask(i_width);

endmodule

@@ hdl/misaligned_access_splitter_core.sv @@
// Misaligned access splitter with region decoder.
//
// The input channel (i_in_valid / o_in_ready) carries CPU reads and writes
// and the device responses to the accesses this block issues. The output
// channel (o_out_valid / i_out_ready) carries either one word-aligned device
// access or the CPU completion. The configuration channel writes the region
// base addresses and is always ready; the user must see that it is written
// only while the block is idle, as the block itself does not enforce this.
//
// Every request is decoded in the cycle it is accepted, and its result sits
// in the output register on the next cycle; throughput is one request per
// cycle while the output is drained. Region lookup is a set of parallel range
// compares on the aligned word address, and lane steering is a byte shifter.
//
// A request is accepted whenever the output register is empty or is being
// drained in the same cycle, so a stalled receiver stops input only once a
// result is waiting. Reset returns the sequencer to idle, empties the output
// register and restores the default base addresses.
module misaligned_access_splitter_core
    import mas_pkg::*;
#(
    parameter int unsigned NUM_REGIONS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_operation,
    input  logic [ADDR_W-1:0]    i_address,
    input  logic [2:0]           i_width_bytes,
    input  logic [DATA_W-1:0]    i_write_data,
    input  logic                 i_response_ok,
    input  logic [DATA_W-1:0]    i_response_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_kind,
    output logic [REGION_W-1:0]  o_region,
    output logic [OFFSET_W-1:0]  o_offset,
    output logic                 o_is_write,
    output logic [3:0]           o_byte_mask,
    output logic [DATA_W-1:0]    o_data,
    output logic                 o_ok
);

    localparam int unsigned NUM_LIVE = (NUM_REGIONS < NUM_TABLE) ? NUM_REGIONS : NUM_TABLE;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_FIRST  = 2'd1;
    localparam logic [1:0] PH_SECOND = 2'd2;

    logic [NUM_LIVE-1:0][ADDR_W-1:0] r_base;
    logic [1:0]                      r_phase;
    logic [1:0]                      n_phase;
    logic [ADDR_W-1:0]               r_saved_address;
    logic [2:0]                      r_saved_width;
    logic                            r_saved_is_write;
    logic [DATA_W-1:0]               r_saved_write_data;
    logic [DATA_W-1:0]               r_first_word;
    logic [DATA_W-1:0]               n_first_word;
    logic                            r_out_valid;
    logic                            n_out_valid;
    t_result                         r_out;
    t_result                         n_out;

    logic              accept;
    logic              idle;
    logic              save;
    logic              issue;
    logic              produce;
    logic              width_ok;
    logic              is_cpu;
    logic [ADDR_W-1:0] src_addr;
    logic [2:0]        src_width;
    logic              src_wr;
    logic [DATA_W-1:0] src_wdata;
    logic [ADDR_W-1:0] word;
    t_lookup           lookup;
    logic              spill;
    logic [3:0]        lane_mask;
    logic [DATA_W-1:0] wr_word;
    logic [DATA_W-1:0] rd_value;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign idle        = r_phase == PH_IDLE;
    assign is_cpu      = i_operation == OP_READ || i_operation == OP_WRITE;
    assign width_ok    = i_width_bytes == 3'd1 || i_width_bytes == 3'd2 ||
                         i_width_bytes == 3'd4;

    // An idle block issues the first word of the incoming request; otherwise
    // the saved request supplies the second word.
    assign src_addr  = idle ? i_address : r_saved_address;
    assign src_width = idle ? i_width_bytes : r_saved_width;
    assign src_wr    = idle ? i_operation[0] : r_saved_is_write;
    assign src_wdata = idle ? i_write_data : r_saved_write_data;
    assign word      = {src_addr[ADDR_W-1:2] + (ADDR_W - 2)'(!idle), 2'b00};

    mas_decode #(
        .NUM_LIVE (NUM_LIVE)
    ) u_decode (
        .i_bases  (r_base),
        .i_word   (word),
        .o_lookup (lookup)
    );

    mas_lanes u_lanes (
        .i_lane       (src_addr[1:0]),
        .i_width      (src_width),
        .i_part       (!idle),
        .i_second     (r_phase != PH_FIRST),
        .i_write_data (src_wdata),
        .i_first_word (r_first_word),
        .i_resp_data  (i_response_data),
        .o_spill      (spill),
        .o_byte_mask  (lane_mask),
        .o_wr_word    (wr_word),
        .o_rd_value   (rd_value)
    );

    always_comb begin
        n_phase      = r_phase;
        n_first_word = r_first_word;
        n_out        = '0;
        produce      = 1'b0;
        issue        = 1'b0;
        save         = 1'b0;
        priority if (accept && is_cpu && idle) begin
            if (!width_ok) begin
                produce    = 1'b1;
                n_out.kind = KIND_DONE;
            end else begin
                save  = 1'b1;
                issue = 1'b1;
            end
        end else if (accept && i_operation == OP_RESP && !idle) begin
            if (!i_response_ok) begin
                produce    = 1'b1;
                n_out.kind = KIND_DONE;
                n_phase    = PH_IDLE;
            end else if (r_phase == PH_FIRST &&
                         (r_saved_is_write ? spill : r_saved_address[1:0] != 2'b00)) begin
                n_first_word = i_response_data;
                issue        = 1'b1;
            end else begin
                produce    = 1'b1;
                n_out.kind = KIND_DONE;
                n_out.ok   = 1'b1;
                n_out.data = r_saved_is_write ? '0 : rd_value;
                n_phase    = PH_IDLE;
            end
        end else begin
            n_phase = r_phase;
        end

        if (issue) begin
            produce = 1'b1;
            if (!lookup.hit) begin
                n_out      = '0;
                n_out.kind = KIND_DONE;
                n_phase    = PH_IDLE;
            end else begin
                n_out.kind      = KIND_ACCESS;
                n_out.region    = lookup.region;
                n_out.offset    = lookup.offset;
                n_out.is_write  = src_wr;
                n_out.byte_mask = src_wr ? lane_mask : 4'h0;
                n_out.data      = src_wr ? wr_word : '0;
                n_phase         = idle ? PH_FIRST : PH_SECOND;
            end
        end
    end

    assign n_out_valid = produce ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_LIVE; i++) begin
                r_base[i] <= BASE_RESET[i];
            end
        end else begin
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
            for (int i = 0; i < NUM_LIVE; i++) begin
                if (i_cfg_valid && i_cfg_index == CFG_IDX_W'(i)) begin
                    r_base[i] <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_first_word <= n_first_word;
        if (save) begin
            r_saved_address    <= i_address;
            r_saved_width      <= i_width_bytes;
            r_saved_is_write   <= i_operation[0];
            r_saved_write_data <= i_write_data;
        end
        if (produce) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out.kind;
    assign o_region    = r_out.region;
    assign o_offset    = r_out.offset;
    assign o_is_write  = r_out.is_write;
    assign o_byte_mask = r_out.byte_mask;
    assign o_data      = r_out.data;
    assign o_ok        = r_out.ok;

endmodule

@@ hdl/mas_checker.sv @@
module mas_checker
    import mas_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic                o_kind,
    input logic [REGION_W-1:0] o_region,
    input logic [OFFSET_W-1:0] o_offset,
    input logic                o_is_write,
    input logic [3:0]          o_byte_mask,
    input logic [DATA_W-1:0]   o_data,
    input logic                o_ok
);

    // An empty output register never holds off a new request.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with an empty output register");

    // A waiting result stays put until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_data) && $stable(o_kind))
        else $error("output result changed while stalled");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_DONE && !o_ok |->
            o_data == '0 && o_region == '0 && o_offset == '0)
        else $error("failed completion carries stray fields");

    a_read_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_ACCESS && !o_is_write |->
            o_byte_mask == 4'h0 && o_data == '0 && !o_ok)
        else $error("device read carries lanes or data");

    // A device write always touches at least one byte lane.
    a_write_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_ACCESS && o_is_write |->
            o_byte_mask != 4'h0 && !o_ok)
        else $error("device write with no byte lanes");

endmodule

bind misaligned_access_splitter_core mas_checker u_mas_checker (.*);

@@ tb/misaligned_access_splitter_core_tb.sv @@
`timescale 1ns / 100ps

module misaligned_access_splitter_core_tb;
    import mas_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 150;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_FIRST,
        SEQ_SECOND
    } t_seq_phase;

    typedef struct packed {
        logic [1:0]        op;
        logic [ADDR_W-1:0] addr;
        logic [2:0]        width;
        logic [DATA_W-1:0] wdata;
        logic              resp_ok;
        logic [DATA_W-1:0] rdata;
    } t_bus_item;

    typedef struct {
        t_seq_phase                       phase;
        logic [ADDR_W-1:0]                addr;
        logic [2:0]                       width;
        logic                             is_wr;
        logic [DATA_W-1:0]                wdata;
        logic [DATA_W-1:0]                first;
        logic [NUM_TABLE-1:0][ADDR_W-1:0] base;
    } t_splitter_state;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [ADDR_W-1:0]    i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [1:0]           i_operation = OP_NONE;
    logic [ADDR_W-1:0]    i_address = '0;
    logic [2:0]           i_width_bytes = '0;
    logic [DATA_W-1:0]    i_write_data = '0;
    logic                 i_response_ok = 1'b0;
    logic [DATA_W-1:0]    i_response_data = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic                 o_kind;
    logic [REGION_W-1:0]  o_region;
    logic [OFFSET_W-1:0]  o_offset;
    logic                 o_is_write;
    logic [3:0]           o_byte_mask;
    logic [DATA_W-1:0]    o_data;
    logic                 o_ok;

    misaligned_access_splitter_core #(
        .NUM_REGIONS(NUM_TABLE)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_address      (i_address),
        .i_width_bytes  (i_width_bytes),
        .i_write_data   (i_write_data),
        .i_response_ok  (i_response_ok),
        .i_response_data(i_response_data),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_region       (o_region),
        .o_offset       (o_offset),
        .o_is_write     (o_is_write),
        .o_byte_mask    (o_byte_mask),
        .o_data         (o_data),
        .o_ok           (o_ok)
    );

    t_splitter_state chk_state;
    t_splitter_state gen_state;
    t_bus_item       bus_requests[$];
    t_result         due_results[$];
    int              sent_cnt = 0;
    int              taken_cnt = 0;
    int              error_count = 0;
    int              in_gap = 0;
    int              out_stall = 0;
    int              idle_cycles = 0;
    bit              calm = 1'b0;
    t_bus_item       next_item;
    t_bus_item       seen_item;
    t_result         got_result;
    t_result         want_result;
    t_result         scratch;

    always #6 i_clk = ~i_clk;

    function automatic logic [3:0] lane_span(input logic [2:0] width);
        if (width == 3'd1) return 4'h1;
        if (width == 3'd2) return 4'h3;
        return 4'hF;
    endfunction

    function automatic logic [DATA_W-1:0] width_mask(input logic [2:0] width);
        if (width == 3'd1) return 32'h0000_00FF;
        if (width == 3'd2) return 32'h0000_FFFF;
        return 32'hFFFF_FFFF;
    endfunction

    function automatic t_splitter_state reset_state();
        t_splitter_state st;
        st.phase = SEQ_IDLE;
        st.addr  = '0;
        st.width = '0;
        st.is_wr = 1'b0;
        st.wdata = '0;
        st.first = '0;
        for (int i = 0; i < NUM_TABLE; i++) st.base[i] = BASE_RESET[i];
        return st;
    endfunction

    // The first region in table order whose window holds the word decides;
    // a word that runs past that region's end is a miss.
    function automatic bit find_region(input logic [NUM_TABLE-1:0][ADDR_W-1:0] bases,
                                       input logic [ADDR_W-1:0] word,
                                       output logic [REGION_W-1:0] rgn,
                                       output logic [OFFSET_W-1:0] offs);
        logic [ADDR_W:0] lo;
        logic [ADDR_W:0] hi;
        logic [ADDR_W:0] w;
        rgn  = '0;
        offs = '0;
        w    = {1'b0, word};
        for (int i = 0; i < NUM_TABLE; i++) begin
            lo = {1'b0, bases[i]};
            hi = lo + (ADDR_W + 1)'(REGION_SIZE[i]);
            if (w >= lo && w < hi) begin
                if (w + 33'd4 > hi) return 1'b0;
                rgn  = REGION_W'(i);
                offs = OFFSET_W'(word - bases[i]);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void issue_access(inout t_splitter_state st, input bit part,
                                         output t_result res);
        logic [1:0]          lane;
        logic [ADDR_W-1:0]   word;
        logic [7:0]          spread;
        logic [REGION_W-1:0] rgn;
        logic [OFFSET_W-1:0] offs;
        res    = '0;
        lane   = st.addr[1:0];
        word   = {st.addr[ADDR_W-1:2], 2'b00} + (part ? 32'd4 : 32'd0);
        spread = {4'b0, lane_span(st.width)} << lane;
        if (!find_region(st.base, word, rgn, offs)) begin
            st.phase = SEQ_IDLE;
            res.kind = KIND_DONE;
            return;
        end
        res.kind     = KIND_ACCESS;
        res.region   = rgn;
        res.offset   = offs;
        res.is_write = st.is_wr;
        if (st.is_wr) begin
            if (!part) begin
                res.byte_mask = spread[3:0];
                res.data      = st.wdata << (8 * lane);
            end else begin
                res.byte_mask = spread[7:4];
                res.data      = (lane != 0) ? st.wdata >> (32 - 8 * lane) : '0;
            end
        end
        st.phase = part ? SEQ_SECOND : SEQ_FIRST;
    endfunction

    function automatic bit split_access(inout t_splitter_state st, input t_bus_item rq,
                                        output t_result res);
        logic [1:0]        lane;
        logic [7:0]        spread;
        bit                second;
        logic [DATA_W-1:0] merged;
        res = '0;
        case (rq.op)
            OP_READ, OP_WRITE: begin
                if (st.phase != SEQ_IDLE) return 1'b0;
                if (rq.width != 3'd1 && rq.width != 3'd2 && rq.width != 3'd4) begin
                    res.kind = KIND_DONE;
                    return 1'b1;
                end
                st.addr  = rq.addr;
                st.width = rq.width;
                st.is_wr = (rq.op == OP_WRITE);
                st.wdata = rq.wdata;
                issue_access(st, 1'b0, res);
                return 1'b1;
            end
            OP_RESP: begin
                if (st.phase == SEQ_IDLE) return 1'b0;
                res.kind = KIND_DONE;
                if (!rq.resp_ok) begin
                    st.phase = SEQ_IDLE;
                    return 1'b1;
                end
                lane   = st.addr[1:0];
                spread = {4'b0, lane_span(st.width)} << lane;
                if (st.phase == SEQ_FIRST) begin
                    second = st.is_wr ? (spread[7:4] != 4'h0) : (lane != 2'd0);
                    if (second) begin
                        st.first = rq.rdata;
                        issue_access(st, 1'b1, res);
                        return 1'b1;
                    end
                    st.phase = SEQ_IDLE;
                    res.ok   = 1'b1;
                    if (!st.is_wr) res.data = rq.rdata & width_mask(st.width);
                    return 1'b1;
                end
                st.phase = SEQ_IDLE;
                res.ok   = 1'b1;
                if (!st.is_wr) begin
                    merged = st.first >> (8 * lane);
                    if (lane != 2'd0) merged |= rq.rdata << (32 - 8 * lane);
                    res.data = merged & width_mask(st.width);
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic t_bus_item random_item();
        t_bus_item it;
        it.op      = OP_NONE;
        it.addr    = $urandom;
        it.width   = 3'($urandom_range(0, 7));
        it.wdata   = $urandom;
        it.resp_ok = 1'($urandom_range(0, 1));
        it.rdata   = $urandom;
        return it;
    endfunction

    task automatic queue_item(input t_bus_item it);
        bus_requests.push_back(it);
        sent_cnt++;
        void'(split_access(gen_state, it, scratch));
    endtask

    task automatic cpu(input logic [1:0] op, input logic [ADDR_W-1:0] a,
                       input logic [2:0] w, input logic [DATA_W-1:0] d);
        t_bus_item it;
        it       = random_item();
        it.op    = op;
        it.addr  = a;
        it.width = w;
        it.wdata = d;
        queue_item(it);
    endtask

    task automatic resp(input logic okv, input logic [DATA_W-1:0] rd);
        t_bus_item it;
        it         = random_item();
        it.op      = OP_RESP;
        it.resp_ok = okv;
        it.rdata   = rd;
        queue_item(it);
    endtask

    function automatic logic [ADDR_W-1:0] pick_address();
        int r;
        int rgn;
        int sz;
        int offs;
        r = $urandom_range(0, 99);
        if (r < 72) begin
            rgn = $urandom_range(0, NUM_TABLE - 1);
            sz  = int'(REGION_SIZE[rgn]);
            case ($urandom_range(0, 3))
                0:       offs = $urandom_range(0, 15);
                1:       offs = sz - $urandom_range(1, 12);
                default: offs = $urandom_range(0, sz - 1);
            endcase
            return gen_state.base[rgn] + offs;
        end
        if (r < 82) return 32'hFFFF_FFFF - $urandom_range(0, 7);
        return $urandom;
    endfunction

    // Mostly well-formed transactions: a CPU request while idle and its
    // responses while busy, with a little noise mixed in.
    task automatic add_random(output bit counted);
        t_bus_item it;
        int        r;
        it      = random_item();
        r       = $urandom_range(0, 99);
        counted = 1'b1;
        if (gen_state.phase == SEQ_IDLE) begin
            if (r < 5) begin
                it.op   = ($urandom_range(0, 1) != 0) ? OP_RESP : OP_NONE;
                counted = 1'b0;
            end else begin
                it.op   = ($urandom_range(0, 1) != 0) ? OP_WRITE : OP_READ;
                it.addr = pick_address();
                if ($urandom_range(0, 9) != 0) begin
                    case ($urandom_range(0, 2))
                        0:       it.width = 3'd1;
                        1:       it.width = 3'd2;
                        default: it.width = 3'd4;
                    endcase
                end
            end
        end else if (r < 12) begin
            case ($urandom_range(0, 2))
                0:       it.op = OP_READ;
                1:       it.op = OP_WRITE;
                default: it.op = OP_NONE;
            endcase
            counted = 1'b0;
        end else begin
            it.op      = OP_RESP;
            it.resp_ok = ($urandom_range(0, 19) != 0);
        end
        queue_item(it);
    endtask

    task automatic run_random(input int n);
        int done_cnt;
        bit counted;
        done_cnt = 0;
        while (done_cnt < n) begin
            add_random(counted);
            if (counted) done_cnt++;
        end
    endtask

    // Drains the queues and the output register before the next phase.
    task automatic settle();
        do @(posedge i_clk);
        while (taken_cnt != sent_cnt || due_results.size() != 0 || o_out_valid);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_bases(input logic [NUM_TABLE-1:0][ADDR_W-1:0] vals);
        for (int i = 0; i < NUM_TABLE; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(i);
            i_cfg_data  <= vals[i];
            do @(posedge i_clk);
            while (!o_cfg_ready);
            chk_state.base[i] = vals[i];
            gen_state.base[i] = vals[i];
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (in_gap > 0) begin
                in_gap     <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (bus_requests.size() != 0) begin
                next_item = bus_requests.pop_front();
                i_operation     <= next_item.op;
                i_address       <= next_item.addr;
                i_width_bytes   <= next_item.width;
                i_write_data    <= next_item.wdata;
                i_response_ok   <= next_item.resp_ok;
                i_response_data <= next_item.rdata;
                i_in_valid      <= 1'b1;
                in_gap          <= draw_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (out_stall > 0) begin
            out_stall   <= out_stall - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            out_stall   <= draw_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got_result = '{o_kind, o_region, o_offset, o_is_write, o_byte_mask, o_data,
                               o_ok};
                if (due_results.size() == 0) begin
                    $error("unexpected result: kind %0h data %0h", o_kind, o_data);
                    error_count++;
                end else begin
                    want_result = due_results.pop_front();
                    check_field("kind", DATA_W'(want_result.kind),
                                DATA_W'(got_result.kind));
                    check_field("region", DATA_W'(want_result.region),
                                DATA_W'(got_result.region));
                    check_field("offset", DATA_W'(want_result.offset),
                                DATA_W'(got_result.offset));
                    check_field("is_write", DATA_W'(want_result.is_write),
                                DATA_W'(got_result.is_write));
                    check_field("byte_mask", DATA_W'(want_result.byte_mask),
                                DATA_W'(got_result.byte_mask));
                    check_field("data", want_result.data, got_result.data);
                    check_field("ok", DATA_W'(want_result.ok), DATA_W'(got_result.ok));
                end
            end
            if (i_in_valid && o_in_ready) begin
                seen_item = '{i_operation, i_address, i_width_bytes, i_write_data,
                              i_response_ok, i_response_data};
                if (split_access(chk_state, seen_item, want_result))
                    due_results.push_back(want_result);
                taken_cnt++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [NUM_TABLE-1:0][ADDR_W-1:0] cfg;
        chk_state = reset_state();
        gen_state = reset_state();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        cpu(OP_READ, 32'h2040_0000, 3'd1, 32'h0);
        resp(1'b1, 32'hA5A5_5A5A);
        cpu(OP_WRITE, 32'h8000_0000, 3'd4, 32'hFFFF_FFFF);
        resp(1'b1, 32'h0);
        cpu(OP_READ, 32'h8000_0003, 3'd2, 32'h0);
        resp(1'b1, 32'h1122_3344);
        resp(1'b1, 32'h5566_7788);
        cpu(OP_WRITE, 32'h8000_0001, 3'd4, 32'hDEAD_BEEF);
        resp(1'b1, 32'h0);
        resp(1'b1, 32'h0);
        cpu(OP_WRITE, 32'h1001_3003, 3'd1, 32'hFFFF_FFFF);
        resp(1'b1, 32'h0);
        cpu(OP_READ, 32'h1000_0006, 3'd1, 32'h0);
        resp(1'b1, 32'hFFFF_FFFF);
        resp(1'b0, 32'hFFFF_FFFF);
        cpu(OP_READ, 32'h0200_FFFE, 3'd4, 32'h0);
        resp(1'b1, 32'h8765_4321);
        cpu(OP_READ, 32'h1000_8FFC, 3'd4, 32'h0);
        cpu(OP_WRITE, 32'h0000_0000, 3'd2, 32'h0);
        cpu(OP_READ, 32'h2040_0000, 3'd0, 32'h0);
        cpu(OP_WRITE, 32'h2040_0000, 3'd7, 32'h0);
        cpu(OP_READ, 32'h2040_0000, 3'd3, 32'h0);
        resp(1'b1, 32'h0);
        cpu(OP_NONE, 32'h2040_0000, 3'd4, 32'h0);
        cpu(OP_READ, 32'h1001_4000, 3'd2, 32'h0);
        cpu(OP_WRITE, 32'h8000_0000, 3'd4, 32'h1234_5678);
        resp(1'b1, 32'hCAFE_F00D);
        settle();

        run_random(ITEMS_PER_PHASE);
        settle();

        calm = 1'b1;
        for (int i = 0; i < NUM_TABLE; i++) cfg[i] = 32'h4000_0000 + $urandom_range(0, 32'h3FFF);
        load_bases(cfg);
        run_random(ITEMS_PER_PHASE);
        settle();

        calm = 1'b0;
        cfg[0] = 32'h0000_0000;
        cfg[1] = 32'hFFFF_FFFF;
        cfg[2] = 32'hFFFF_FFFC;
        cfg[3] = 32'hFFFF_0000;
        cfg[4] = 32'hFFFF_F000;
        cfg[5] = 32'h0000_0001;
        cfg[6] = 32'hFFFF_FF80;
        cfg[7] = 32'h0001_0000;
        load_bases(cfg);
        cpu(OP_READ, 32'hFFFF_FFFE, 3'd4, 32'h0);
        resp(1'b1, 32'hFFEE_DDCC);
        resp(1'b1, 32'h0102_0304);
        cpu(OP_WRITE, 32'hFFFF_FFFF, 3'd2, 32'hFFFF_ABCD);
        resp(1'b1, 32'h0);
        resp(1'b1, 32'h0);
        run_random(ITEMS_PER_PHASE);
        settle();

        for (int i = 0; i < NUM_TABLE; i++) cfg[i] = $urandom;
        load_bases(cfg);
        run_random(ITEMS_PER_PHASE);
        settle();

        for (int i = 0; i < NUM_TABLE; i++) cfg[i] = BASE_RESET[i];
        load_bases(cfg);
        run_random(ITEMS_PER_PHASE);
        settle();

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/mas_pkg.sv
hdl/mas_decode.sv
hdl/mas_lanes.sv
hdl/misaligned_access_splitter_core.sv
hdl/mas_checker.sv
tb/misaligned_access_splitter_core_tb.sv
